### design/mfir_pkg.sv
// ----------------------------------------------------------------------------
// mfir_pkg
// Shared types and codes for the multichannel FIR filter bank.
// ----------------------------------------------------------------------------
package mfir_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEFF_W  = 16;
    localparam int PROD_W   = SAMPLE_W + COEFF_W;
    localparam int NUM_PORT_CH = 4;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEFF_W-1:0]  t_coeff;
    typedef logic signed [PROD_W-1:0]   t_prod;

    // request codes
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_COEFF  = 2'd1;
    localparam logic [1:0] REQ_GEOM   = 2'd2;

    // register indexes
    localparam logic REG_ACT_CH    = 1'b0;
    localparam logic REG_ACT_BANKS = 1'b1;

endpackage

### design/multichannel_fir_filter_bank.sv
// ----------------------------------------------------------------------------
// multichannel_fir_filter_bank
// Per-channel circular histories, per-bank coefficients; one MAC lane per
// channel iterated over the taps of each active bank.
// ----------------------------------------------------------------------------
//  channel   signals                        direction
//  input     i_valid / o_stall, i_* fields  in
//  output    o_valid / i_stall, o_* fields  out
//  config    psel penable pwrite paddr ...  APB write/read
//
// A sample frame is stored, then the taps of each active bank are iterated by
// the single MAC per lane and its two-stage memory read and multiply.
// After reset a clearing pass zeroes both memories; no transfer is taken
// meanwhile.
// A stalled result holds the sequencer before the next bank's result load.
module multichannel_fir_filter_bank #(
    parameter int CHANNELS      = 4,
    parameter int BANKS         = 8,
    parameter int MAX_TAPS      = 32,
    parameter int HISTORY_DEPTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_req_type,
    input  logic signed [15:0]    i_sample_ch0,
    input  logic signed [15:0]    i_sample_ch1,
    input  logic signed [15:0]    i_sample_ch2,
    input  logic signed [15:0]    i_sample_ch3,
    input  logic [2:0]            i_bank_select,
    input  logic [4:0]            i_tap_index,
    input  logic signed [15:0]    i_coeff_value,
    input  logic [5:0]            i_tap_count,
    input  logic [4:0]            i_frac_shift,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [2:0]            o_bank_index,
    output logic signed [15:0]    o_filtered_ch0,
    output logic signed [15:0]    o_filtered_ch1,
    output logic signed [15:0]    o_filtered_ch2,
    output logic signed [15:0]    o_filtered_ch3,
    output logic                  o_last_of_run
);

    localparam int HA     = $clog2(HISTORY_DEPTH);
    localparam int NCOEF  = BANKS * MAX_TAPS;
    localparam int CA     = (NCOEF > 1) ? $clog2(NCOEF) : 1;
    localparam int CLR_N  = (HISTORY_DEPTH > NCOEF) ? HISTORY_DEPTH : NCOEF;
    localparam int CLW    = (CLR_N > 1) ? $clog2(CLR_N) : 1;
    localparam int TW     = $clog2(MAX_TAPS + 1);
    localparam int BIW    = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int BW     = $clog2(BANKS + 1);
    localparam int ACC_W  = mfir_pkg::PROD_W + $clog2(MAX_TAPS) + 1;
    localparam int NCH    = mfir_pkg::NUM_PORT_CH;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_BANK  = 3'd2;
    localparam logic [2:0] S_MAC   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]             r_state;
    logic [CLW-1:0]         r_clr;
    logic [2:0]             r_act_ch;
    logic [3:0]             r_act_banks;
    logic [HA-1:0]          r_wp;
    logic [TW-1:0]          r_tcnt [BANKS];
    logic [4:0]             r_shift [BANKS];
    logic [BW-1:0]          r_b;
    logic [CA-1:0]          r_cbase;
    logic [TW-1:0]          r_n;
    logic [TW-1:0]          r_k;
    logic [HA-1:0]          r_haddr;
    logic [CA-1:0]          r_caddr;
    logic                   r_v1;
    logic                   r_v2;
    mfir_pkg::t_coeff       r_crd;
    mfir_pkg::t_coeff       coef_mem [NCOEF];
    mfir_pkg::t_sample      r_hrd  [CHANNELS];
    mfir_pkg::t_prod        r_prod [CHANNELS];
    logic signed [ACC_W-1:0] r_acc [CHANNELS];

    mfir_pkg::t_sample      in_smp [NCH];
    logic signed [15:0]     res    [NCH];
    logic                   in_xfer;
    logic                   cfg_wr;
    logic                   issue;
    logic                   out_load;
    logic                   last_bank;
    logic [BIW-1:0]         bidx;

    assign in_smp[0] = i_sample_ch0;
    assign in_smp[1] = i_sample_ch1;
    assign in_smp[2] = i_sample_ch2;
    assign in_smp[3] = i_sample_ch3;

    assign pready  = 1'b1;
    assign o_stall = (r_state != S_IDLE);
    assign in_xfer = i_valid && !o_stall;
    assign cfg_wr  = psel && penable && pwrite;
    assign issue   = (r_state == S_MAC) && (r_k < r_n);
    assign bidx    = r_b[BIW-1:0];
    assign last_bank = ({{(32-BW){1'b0}}, r_b} + 32'd1) == {28'd0, r_act_banks};
    assign out_load  = (r_state == S_DONE) && (!o_valid || !i_stall);

    always_comb begin
        prdata = 32'd0;
        unique case (paddr[2])
            mfir_pkg::REG_ACT_CH:    prdata = {29'd0, r_act_ch};
            mfir_pkg::REG_ACT_BANKS: prdata = {28'd0, r_act_banks};
            default:                 prdata = 32'd0;
        endcase
    end

    // configuration registers, stored clamped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_ch    <= 3'd0;
            r_act_banks <= 4'd0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                mfir_pkg::REG_ACT_CH:
                    r_act_ch <= (int'(pwdata[2:0]) > CHANNELS) ? 3'(CHANNELS) : pwdata[2:0];
                mfir_pkg::REG_ACT_BANKS:
                    r_act_banks <= (int'(pwdata[3:0]) > BANKS) ? 4'(BANKS) : pwdata[3:0];
                default: ;
            endcase
        end
    end

    // bank geometry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < BANKS; b++) begin
                r_tcnt[b]  <= '0;
                r_shift[b] <= '0;
            end
        end else if (in_xfer && i_req_type == mfir_pkg::REQ_GEOM
                     && int'(i_bank_select) < BANKS) begin
            r_tcnt[BIW'(i_bank_select)]  <= (int'(i_tap_count) > MAX_TAPS) ?
                                            TW'(MAX_TAPS) : TW'(i_tap_count);
            r_shift[BIW'(i_bank_select)] <= i_frac_shift;
        end
    end

    // coefficient memory: clear pass, single write port, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            if (int'(r_clr) < NCOEF) coef_mem[CA'(r_clr)] <= '0;
        end else if (in_xfer && i_req_type == mfir_pkg::REQ_COEFF
                     && int'(i_bank_select) < BANKS && int'(i_tap_index) < MAX_TAPS) begin
            coef_mem[CA'(int'(i_bank_select) * MAX_TAPS + int'(i_tap_index))] <= i_coeff_value;
        end
        if (issue) r_crd <= coef_mem[r_caddr];
    end

    // one history memory and one MAC per lane
    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        mfir_pkg::t_sample hist [HISTORY_DEPTH];

        always_ff @(posedge i_clk) begin
            if (r_state == S_CLEAR) begin
                if (int'(r_clr) < HISTORY_DEPTH) hist[HA'(r_clr)] <= '0;
            end else if (in_xfer && i_req_type == mfir_pkg::REQ_SAMPLE
                         && c < int'(r_act_ch)) begin
                hist[r_wp] <= in_smp[c];
            end
            if (issue) r_hrd[c] <= hist[r_haddr];
            if (r_v1) r_prod[c] <= r_hrd[c] * r_crd;
        end

        always_ff @(posedge i_clk) begin
            if (r_state == S_BANK) begin
                r_acc[c] <= '0;
            end else if (r_v2) begin
                r_acc[c] <= r_acc[c] + ACC_W'(r_prod[c]);
            end
        end
    end

    // final scaling: floor shift then saturate
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            res[c] = '0;
        end
        for (int c = 0; c < CHANNELS; c++) begin
            logic signed [ACC_W-1:0] sh;
            sh = r_acc[c] >>> r_shift[bidx];
            if (c >= int'(r_act_ch))            res[c] = '0;
            else if (sh > ACC_W'(32767))        res[c] = 16'sh7fff;
            else if (sh < -ACC_W'(32768))       res[c] = 16'sh8000;
            else                                res[c] = sh[15:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_wp    <= '0;
            r_b     <= '0;
            r_cbase <= '0;
            r_n     <= '0;
            r_k     <= '0;
            r_haddr <= '0;
            r_caddr <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (int'(r_clr) == CLR_N - 1) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_xfer && i_req_type == mfir_pkg::REQ_SAMPLE) begin
                        r_wp    <= r_wp + 1'b1;
                        r_b     <= '0;
                        r_cbase <= '0;
                        if (r_act_banks != 4'd0) r_state <= S_BANK;
                    end
                end
                S_BANK: begin
                    r_n     <= r_tcnt[bidx];
                    r_k     <= '0;
                    r_haddr <= r_wp - HA'(r_tcnt[bidx]);
                    r_caddr <= r_cbase;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    if (issue) begin
                        r_k     <= r_k + 1'b1;
                        r_haddr <= r_haddr + 1'b1;
                        r_caddr <= r_caddr + 1'b1;
                    end else if (!r_v1 && !r_v2) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_b     <= r_b + 1'b1;
                        r_cbase <= r_cbase + CA'(MAX_TAPS);
                        r_state <= last_bank ? S_IDLE : S_BANK;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (out_load) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_bank_index   <= 3'(r_b);
            o_filtered_ch0 <= res[0];
            o_filtered_ch1 <= res[1];
            o_filtered_ch2 <= res[2];
            o_filtered_ch3 <= res[3];
            o_last_of_run  <= last_bank;
        end
    end

    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_k <= r_n))
        else $error("tap counter ran past tap count");

    a_bank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> ({{(32-BW){1'b0}}, r_b} < {28'd0, r_act_banks}))
        else $error("result loaded for inactive bank");

    a_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (!r_v1 && !r_v2))
        else $error("MAC pipeline busy at bank end");

endmodule
